// ===== hw/rtl/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// Shared widths, operation codes, divider lane types and saturation helpers
// for the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int FIELD_W = 32;
    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = 2 * FIELD_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int ADD_W   = FIELD_W + 1;
    // integer bits of the quotient word
    localparam int INT_W   = DATA_W - FRAC_W;

    localparam logic signed [SUM_W-1:0] SAT_MAX = (SUM_W'(1) << (DATA_W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef struct packed {
        logic              neg;
        logic              big;
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              neg;
        logic              big;
        logic [DATA_W-1:0] q;
    } t_div_rsp;

    typedef struct packed {
        logic               ovf;
        logic [FIELD_W-1:0] val;
    } t_sat;

    function automatic t_sat sat_value(input logic signed [SUM_W-1:0] v);
        t_sat r;
        r.ovf = 1'b0;
        if (v > SAT_MAX) begin
            r.ovf = 1'b1;
            r.val = FIELD_W'(SAT_MAX);
        end else if (v < SAT_MIN) begin
            r.ovf = 1'b1;
            r.val = FIELD_W'(SAT_MIN);
        end else begin
            r.val = v[FIELD_W-1:0];
        end
        return r;
    endfunction

    function automatic t_sat sat_quot(input t_div_rsp d);
        logic signed [SUM_W-1:0] v;
        t_sat r;
        v = SUM_W'(d.q);
        if (d.neg) begin
            v = -v;
        end
        r = sat_value(v);
        // integer part already past the field range
        if (d.big) begin
            r.ovf = 1'b1;
            r.val = d.neg ? FIELD_W'(SAT_MIN) : FIELD_W'(SAT_MAX);
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/cau_div_lane.sv =====
// ----------------------------------------------------------------------------
// cau_div_lane
// Pipelined restoring divider, one quotient bit per stage. Gives the
// magnitude of (mag << FRAC_W) / den truncated, DATA_W bits wide.
// ----------------------------------------------------------------------------
module cau_div_lane (
    input  logic              i_clk,
    input  logic              i_en,
    input  cau_pkg::t_div_req i_req,
    output cau_pkg::t_div_rsp o_rsp
);
    import cau_pkg::*;

    logic [PROD_W-1:0] r_rem [0:DATA_W];
    logic [PROD_W-1:0] r_den [0:DATA_W];
    logic [DATA_W-1:0] r_nlo [0:DATA_W];
    logic [DATA_W-1:0] r_q   [0:DATA_W];
    logic              r_neg [0:DATA_W];
    logic              r_big [0:DATA_W];

    logic [PROD_W-1:0] n_rem [0:DATA_W-1];
    logic [DATA_W-1:0] n_q   [0:DATA_W-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_req.mag >> INT_W;
            // low dividend bits still to be brought down
            r_nlo[0] <= DATA_W'(i_req.mag << FRAC_W);
            r_den[0] <= i_req.den;
            r_q[0]   <= '0;
            r_neg[0] <= i_req.neg;
            r_big[0] <= i_req.big;
        end
    end

    for (genvar k = 0; k < DATA_W; k++) begin : g_step
        logic [PROD_W-1:0] rem_sh;
        logic              ge;

        always_comb begin
            rem_sh   = {r_rem[k][PROD_W-2:0], r_nlo[k][DATA_W-1]};
            ge       = (rem_sh >= r_den[k]);
            n_rem[k] = ge ? (rem_sh - r_den[k]) : rem_sh;
            n_q[k]   = {r_q[k][DATA_W-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= n_rem[k];
                r_nlo[k+1] <= {r_nlo[k][DATA_W-2:0], 1'b0};
                r_den[k+1] <= r_den[k];
                r_q[k+1]   <= n_q[k];
                r_neg[k+1] <= r_neg[k];
                r_big[k+1] <= r_big[k];
            end
        end
    end

    assign o_rsp = '{neg: r_neg[DATA_W], big: r_big[DATA_W], q: r_q[DATA_W]};

endmodule

// ===== hw/rtl/complex_arith_unit.sv =====
// ----------------------------------------------------------------------------
// complex_arith_unit
// Complex add, subtract, multiply and divide on signed Q16.16 operands,
// with saturation and divide-by-zero flag.
// ----------------------------------------------------------------------------
// throughput: one beat per cycle, the whole pipeline moves as one and holds on stall
// depth is set by the 32-stage restoring divider, one quotient bit per stage
// reset: synchronous, active low, clears all valid bits; data registers are not reset
module complex_arith_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0]                          i_operation,
    input  logic signed [cau_pkg::FIELD_W-1:0]  i_a_real,
    input  logic signed [cau_pkg::FIELD_W-1:0]  i_a_imag,
    input  logic signed [cau_pkg::FIELD_W-1:0]  i_b_real,
    input  logic signed [cau_pkg::FIELD_W-1:0]  i_b_imag,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [cau_pkg::FIELD_W-1:0]  o_res_real,
    output logic signed [cau_pkg::FIELD_W-1:0]  o_res_imag,
    output logic                                o_div_zero,
    output logic                                o_overflow
);
    import cau_pkg::*;

    typedef struct packed {
        logic               is_div;
        logic               dz;
        logic               ovf;
        logic [FIELD_W-1:0] re;
        logic [FIELD_W-1:0] im;
    } t_side;

    logic w_adv;

    // product stage
    logic                    r_p_vld;
    t_op                     r_p_op;
    logic                    r_p_dz;
    logic signed [ADD_W-1:0] r_p_add_re, r_p_add_im;
    logic signed [PROD_W-1:0] r_p_rr, r_p_ii, r_p_ir, r_p_ri, r_p_sqr, r_p_sqi;

    // combine stage
    logic                    r_c_vld;
    t_op                     r_c_op;
    logic                    r_c_dz;
    logic signed [SUM_W-1:0] r_c_re, r_c_im;
    logic [PROD_W-1:0]       r_c_den;
    logic signed [SUM_W-1:0] n_c_re, n_c_im;

    // divider alignment
    logic     r_vld  [0:DATA_W];
    t_side    r_side [0:DATA_W];
    t_side    n_side;
    t_div_req n_req_re, n_req_im;
    t_div_rsp w_rsp_re, w_rsp_im;

    // output register
    logic               r_o_vld;
    logic [FIELD_W-1:0] r_o_re, r_o_im;
    logic               r_o_dz, r_o_ovf;
    logic [FIELD_W-1:0] n_o_re, n_o_im;
    logic               n_o_dz, n_o_ovf;

    assign w_adv   = !r_o_vld || i_ready;
    assign o_ready = w_adv;

    // ---- product stage ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (w_adv) begin
            r_p_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p_op  <= t_op'(i_operation);
            r_p_dz  <= (i_b_real == '0) && (i_b_imag == '0);
            if (t_op'(i_operation) == OP_SUB) begin
                r_p_add_re <= ADD_W'(i_a_real) - ADD_W'(i_b_real);
                r_p_add_im <= ADD_W'(i_a_imag) - ADD_W'(i_b_imag);
            end else begin
                r_p_add_re <= ADD_W'(i_a_real) + ADD_W'(i_b_real);
                r_p_add_im <= ADD_W'(i_a_imag) + ADD_W'(i_b_imag);
            end
            r_p_rr  <= i_a_real * i_b_real;
            r_p_ii  <= i_a_imag * i_b_imag;
            r_p_ir  <= i_a_imag * i_b_real;
            r_p_ri  <= i_a_real * i_b_imag;
            r_p_sqr <= i_b_real * i_b_real;
            r_p_sqi <= i_b_imag * i_b_imag;
        end
    end

    // ---- combine stage ----
    always_comb begin
        case (r_p_op)
            OP_MUL: begin
                n_c_re = SUM_W'(r_p_rr) - SUM_W'(r_p_ii);
                n_c_im = SUM_W'(r_p_ir) + SUM_W'(r_p_ri);
            end
            OP_DIV: begin
                n_c_re = SUM_W'(r_p_rr) + SUM_W'(r_p_ii);
                n_c_im = SUM_W'(r_p_ir) - SUM_W'(r_p_ri);
            end
            default: begin
                n_c_re = SUM_W'(r_p_add_re);
                n_c_im = SUM_W'(r_p_add_im);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (w_adv) begin
            r_c_vld <= r_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c_op  <= r_p_op;
            r_c_dz  <= r_p_dz;
            r_c_re  <= n_c_re;
            r_c_im  <= n_c_im;
            r_c_den <= $unsigned(r_p_sqr) + $unsigned(r_p_sqi);
        end
    end

    // ---- divider setup and non-divide results ----
    always_comb begin
        logic signed [SUM_W-1:0] v_re, v_im;
        t_sat s_re, s_im;
        v_re = (r_c_op == OP_MUL) ? (r_c_re >>> FRAC_W) : r_c_re;
        v_im = (r_c_op == OP_MUL) ? (r_c_im >>> FRAC_W) : r_c_im;
        s_re = sat_value(v_re);
        s_im = sat_value(v_im);
        n_side.is_div = (r_c_op == OP_DIV);
        n_side.dz     = r_c_dz;
        n_side.ovf    = s_re.ovf || s_im.ovf;
        n_side.re     = s_re.val;
        n_side.im     = s_im.val;

        n_req_re.neg = r_c_re[SUM_W-1];
        n_req_re.mag = PROD_W'(r_c_re[SUM_W-1] ? -r_c_re : r_c_re);
        n_req_re.den = r_c_den;
        n_req_re.big = ({{INT_W{1'b0}}, n_req_re.mag} >= {r_c_den, {INT_W{1'b0}}});

        n_req_im.neg = r_c_im[SUM_W-1];
        n_req_im.mag = PROD_W'(r_c_im[SUM_W-1] ? -r_c_im : r_c_im);
        n_req_im.den = r_c_den;
        n_req_im.big = ({{INT_W{1'b0}}, n_req_im.mag} >= {r_c_den, {INT_W{1'b0}}});
    end

    cau_div_lane u_div_re (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_req (n_req_re),
        .o_rsp (w_rsp_re)
    );

    cau_div_lane u_div_im (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_req (n_req_im),
        .o_rsp (w_rsp_im)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DATA_W; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_vld[0] <= r_c_vld;
            for (int k = 0; k < DATA_W; k++) begin
                r_vld[k+1] <= r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side[0] <= n_side;
            for (int k = 0; k < DATA_W; k++) begin
                r_side[k+1] <= r_side[k];
            end
        end
    end

    // ---- final select ----
    always_comb begin
        t_sat q_re, q_im;
        q_re = sat_quot(w_rsp_re);
        q_im = sat_quot(w_rsp_im);
        if (!r_side[DATA_W].is_div) begin
            n_o_re  = r_side[DATA_W].re;
            n_o_im  = r_side[DATA_W].im;
            n_o_dz  = 1'b0;
            n_o_ovf = r_side[DATA_W].ovf;
        end else if (r_side[DATA_W].dz) begin
            n_o_re  = '0;
            n_o_im  = '0;
            n_o_dz  = 1'b1;
            n_o_ovf = 1'b0;
        end else begin
            n_o_re  = q_re.val;
            n_o_im  = q_im.val;
            n_o_dz  = 1'b0;
            n_o_ovf = q_re.ovf || q_im.ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_adv) begin
            r_o_vld <= r_vld[DATA_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_o_re  <= n_o_re;
            r_o_im  <= n_o_im;
            r_o_dz  <= n_o_dz;
            r_o_ovf <= n_o_ovf;
        end
    end

    assign o_valid    = r_o_vld;
    assign o_res_real = r_o_re;
    assign o_res_imag = r_o_im;
    assign o_div_zero = r_o_dz;
    assign o_overflow = r_o_ovf;

`ifndef NO_ASSERTIONS
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_div_zero |-> o_res_real == '0 && o_res_imag == '0 && !o_overflow)
        else $error("divide-by-zero beat with nonzero result or overflow");

    a_stall_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld && !i_ready |-> !o_ready)
        else $error("input taken while output beat is held");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_p_vld) && $stable(r_c_vld) && $stable(r_vld[DATA_W]))
        else $error("pipeline valid bits moved during stall");
`endif

endmodule
